// ===== hdl/bffla_pkg.sv =====
`timescale 1ns / 1ps
package bffla_pkg;
   localparam int LIST_DEPTH = 16;
   localparam int ALIGNMENT  = 16;
   localparam int ADDR_BITS  = 32;
   localparam int IDX_BITS   = $clog2(LIST_DEPTH);
   localparam int CNT_BITS   = $clog2(LIST_DEPTH + 1);
   localparam int ALIGN_BITS = $clog2(ALIGNMENT);

   localparam logic CMD_ALLOC = 1'b0;
   localparam logic CMD_FREE  = 1'b1;

   typedef struct packed {
      logic [ADDR_BITS-1:0] off;
      logic [ADDR_BITS-1:0] len;
   } chunk_type;

   typedef struct packed {
      logic command;
      logic [31:0] request_size;
      logic [31:0] block_base;
      logic [31:0] block_length;
   } req_type;

   typedef struct packed {
      logic status;
      logic [31:0] data_offset;
      logic [31:0] granted_base;
      logic [31:0] granted_length;
   } rsp_type;

   // controller to datapath
   typedef struct packed {
      logic load;        // capture request, start over
      logic scan;        // examine the entry at the scan index
      logic alloc_take;  // prepare alloc result and remainder
      logic free_merge;  // form merged chunk
      logic rem_start;   // begin removing rm_a
      logic rem_second;  // begin removing rm_b
      logic shift_step;  // one shift step
      logic ins_start;   // begin insert of work chunk
      logic ins_scan;    // step insert position search
      logic ins_write;   // place work chunk
      logic out_load;    // load response register
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic is_free;
      logic alloc_fail;
      logic scan_done;
      logic has_rm_a;
      logic has_rm_b;
      logic shift_done;
      logic ins_found;
      logic ins_needed;
   } sts_type;
endpackage

// ===== hdl/bffla_if.sv =====
`timescale 1ns / 1ps
interface bffla_req_if;
   logic valid;
   logic ready;
   bffla_pkg::req_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

interface bffla_rsp_if;
   logic valid;
   logic ready;
   bffla_pkg::rsp_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

// ===== hdl/bffla_datapath.sv =====
`timescale 1ns / 1ps
module bffla_datapath (
   input  logic clock,
   input  logic reset,
   input  bffla_pkg::req_type req_in,
   input  bffla_pkg::cmd_type cmd,
   output bffla_pkg::sts_type sts,
   output bffla_pkg::rsp_type rsp_data
);
   localparam int AB = bffla_pkg::ADDR_BITS;
   localparam int IB = bffla_pkg::IDX_BITS;
   localparam int CB = bffla_pkg::CNT_BITS;
   localparam logic [AB:0] AMASK = {1'b0, {AB{1'b1}}};

   bffla_pkg::chunk_type list_ff [bffla_pkg::LIST_DEPTH];
   logic [CB-1:0] count_ff;
   bffla_pkg::req_type req_ff;
   logic [AB:0] need_ff;
   logic [CB-1:0] idx_ff;
   logic found_ff, prev_ok_ff, next_ok_ff;
   logic [IB-1:0] found_ix_ff, prev_ix_ff, next_ix_ff;
   bffla_pkg::chunk_type prev_c_ff, next_c_ff, work_ff;
   logic [CB-1:0] rm_a_ff, rm_b_ff;
   logic has_a_ff, has_b_ff, ins_need_ff;
   logic [CB-1:0] sh_ff;
   logic [CB-1:0] pos_ff;
   logic fail_ff;
   bffla_pkg::rsp_type res_ff, rsp_ff;

   bffla_pkg::chunk_type ent;
   logic [AB:0] need_in, end_sum, pend_sum;
   logic [IB-1:0] idx_i;

   // round the request up and add one unit for the header
   assign need_in = (({1'b0, req_in.request_size} + (AB+1)'(bffla_pkg::ALIGNMENT - 1))
                     >> bffla_pkg::ALIGN_BITS << bffla_pkg::ALIGN_BITS)
                    + (AB+1)'(bffla_pkg::ALIGNMENT);
   assign idx_i = idx_ff[IB-1:0];
   assign ent = list_ff[idx_i];
   // full-width sums: an end past the address space never matches
   assign end_sum = {1'b0, req_ff.block_base} + {1'b0, req_ff.block_length};
   assign pend_sum = {1'b0, ent.off} + {1'b0, ent.len};

   function automatic logic [AB-1:0] sat(input logic [AB-1:0] a, input logic [AB-1:0] b);
      logic [AB:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[AB] ? {AB{1'b1}} : s[AB-1:0];
   endfunction

   logic [AB:0] aligned_off;
   assign aligned_off = (({1'b0, list_ff[found_ix_ff].off}
                          + (AB+1)'(bffla_pkg::ALIGNMENT - 1))
                         >> bffla_pkg::ALIGN_BITS << bffla_pkg::ALIGN_BITS)
                        + (AB+1)'(bffla_pkg::ALIGNMENT);

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         if (cmd.load) begin
            req_ff <= req_in;
            need_ff <= need_in;
            idx_ff <= '0;
            found_ff <= 1'b0;
            prev_ok_ff <= 1'b0;
            next_ok_ff <= 1'b0;
            has_a_ff <= 1'b0;
            has_b_ff <= 1'b0;
            ins_need_ff <= 1'b0;
            fail_ff <= 1'b0;
            res_ff <= '0;
         end
         // scan the list head to tail
         if (cmd.scan && idx_ff < count_ff) begin
            if (req_ff.command == bffla_pkg::CMD_ALLOC) begin
               if ({1'b0, ent.len} >= need_ff) begin
                  found_ff <= 1'b1;
                  found_ix_ff <= idx_i;
               end
            end else begin
               if ({1'b0, ent.off} == end_sum) begin
                  next_ok_ff <= 1'b1;
                  next_ix_ff <= idx_i;
                  next_c_ff <= ent;
               end else if (pend_sum == {1'b0, req_ff.block_base}) begin
                  prev_ok_ff <= 1'b1;
                  prev_ix_ff <= idx_i;
                  prev_c_ff <= ent;
               end
            end
            idx_ff <= idx_ff + 1'b1;
         end
         // alloc: build result and remainder
         if (cmd.alloc_take) begin
            if (!found_ff || need_ff > AMASK) begin
               fail_ff <= 1'b1;
               res_ff <= '{status: 1'b1, default: '0};
            end else begin
               res_ff.status <= 1'b0;
               res_ff.data_offset <= 32'(aligned_off[AB-1:0]);
               res_ff.granted_base <= 32'(list_ff[found_ix_ff].off);
               res_ff.granted_length <= 32'(need_ff[AB-1:0]);
               rm_a_ff <= CB'(found_ix_ff);
               has_a_ff <= 1'b1;
               work_ff.off <= list_ff[found_ix_ff].off + need_ff[AB-1:0];
               work_ff.len <= list_ff[found_ix_ff].len - need_ff[AB-1:0];
               ins_need_ff <= {1'b0, list_ff[found_ix_ff].len} > need_ff;
            end
         end
         // free: merge neighbors, remove higher index first
         if (cmd.free_merge) begin
            work_ff.off <= prev_ok_ff ? prev_c_ff.off : req_ff.block_base;
            work_ff.len <= sat(sat(req_ff.block_length, prev_ok_ff ? prev_c_ff.len : '0),
                               next_ok_ff ? next_c_ff.len : '0);
            ins_need_ff <= 1'b1;
            if (prev_ok_ff && next_ok_ff) begin
               has_a_ff <= 1'b1;
               has_b_ff <= 1'b1;
               rm_a_ff <= CB'(prev_ix_ff > next_ix_ff ? prev_ix_ff : next_ix_ff);
               rm_b_ff <= CB'(prev_ix_ff > next_ix_ff ? next_ix_ff : prev_ix_ff);
            end else begin
               has_a_ff <= prev_ok_ff | next_ok_ff;
               rm_a_ff <= CB'(prev_ok_ff ? prev_ix_ff : next_ix_ff);
            end
         end
         if (cmd.rem_start) sh_ff <= rm_a_ff;
         if (cmd.rem_second) sh_ff <= rm_b_ff;
         // shift entries down by one
         if (cmd.shift_step) begin
            if (sh_ff + 1'b1 < count_ff) begin
               list_ff[sh_ff[IB-1:0]] <= list_ff[IB'(sh_ff + 1'b1)];
               sh_ff <= sh_ff + 1'b1;
            end else begin
               count_ff <= count_ff - 1'b1;
            end
         end
         if (cmd.ins_start) pos_ff <= '0;
         if (cmd.ins_scan) pos_ff <= pos_ff + 1'b1;
         // insert: shift tail up then place chunk
         if (cmd.ins_write) begin
            if (pos_ff < CB'(bffla_pkg::LIST_DEPTH)) begin
               for (int i = bffla_pkg::LIST_DEPTH - 1; i > 0; i--) begin
                  if (CB'(i) > pos_ff && CB'(i) <= count_ff) list_ff[i] <= list_ff[i-1];
               end
               list_ff[pos_ff[IB-1:0]] <= work_ff;
               if (count_ff < CB'(bffla_pkg::LIST_DEPTH)) count_ff <= count_ff + 1'b1;
            end
         end
         if (cmd.out_load) rsp_ff <= res_ff;
      end
   end

   logic ins_stop;
   assign ins_stop = (pos_ff >= count_ff) || (work_ff.len > list_ff[pos_ff[IB-1:0]].len);

   assign sts.is_free = req_ff.command;
   assign sts.alloc_fail = fail_ff;
   assign sts.scan_done = idx_ff >= count_ff;
   assign sts.has_rm_a = has_a_ff;
   assign sts.has_rm_b = has_b_ff;
   assign sts.shift_done = !(sh_ff + 1'b1 < count_ff);
   assign sts.ins_found = ins_stop;
   assign sts.ins_needed = ins_need_ff;
   assign rsp_data = rsp_ff;
endmodule

// ===== hdl/bffla_ctrl.sv =====
`timescale 1ns / 1ps
module bffla_ctrl (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_ready,
   output logic rsp_valid,
   input  logic rsp_ready,
   input  bffla_pkg::sts_type sts,
   output bffla_pkg::cmd_type cmd
);
   localparam logic [3:0] S_IDLE = 4'd0;
   localparam logic [3:0] S_SCAN = 4'd1;
   localparam logic [3:0] S_TAKE = 4'd2;
   localparam logic [3:0] S_REMA = 4'd3;
   localparam logic [3:0] S_SHA  = 4'd4;
   localparam logic [3:0] S_REMB = 4'd5;
   localparam logic [3:0] S_SHB  = 4'd6;
   localparam logic [3:0] S_INS  = 4'd7;
   localparam logic [3:0] S_INSP = 4'd8;
   localparam logic [3:0] S_DONE = 4'd9;

   logic [3:0] state_ff, state_in;
   logic out_ff, out_in;

   assign req_ready = (state_ff == S_IDLE) && !out_ff;
   assign rsp_valid = out_ff;

   // sequence one request through scan, removal and insertion
   always_comb begin
      state_in = state_ff;
      out_in = out_ff && !rsp_ready;
      cmd = '0;
      case (state_ff)
         S_IDLE: begin
            if (req_valid && req_ready) begin
               cmd.load = 1'b1;
               state_in = S_SCAN;
            end
         end
         S_SCAN: begin
            if (sts.scan_done) state_in = S_TAKE;
            else cmd.scan = 1'b1;
         end
         S_TAKE: begin
            if (sts.is_free) cmd.free_merge = 1'b1;
            else cmd.alloc_take = 1'b1;
            state_in = S_REMA;
         end
         S_REMA: begin
            if (!sts.is_free && sts.alloc_fail) state_in = S_DONE;
            else if (sts.has_rm_a) begin
               cmd.rem_start = 1'b1;
               state_in = S_SHA;
            end else state_in = S_INS;
         end
         S_SHA: begin
            cmd.shift_step = 1'b1;
            if (sts.shift_done) state_in = sts.has_rm_b ? S_REMB : S_INS;
         end
         S_REMB: begin
            cmd.rem_second = 1'b1;
            state_in = S_SHB;
         end
         S_SHB: begin
            cmd.shift_step = 1'b1;
            if (sts.shift_done) state_in = S_INS;
         end
         S_INS: begin
            if (sts.ins_needed) begin
               cmd.ins_start = 1'b1;
               state_in = S_INSP;
            end else state_in = S_DONE;
         end
         S_INSP: begin
            if (sts.ins_found) begin
               cmd.ins_write = 1'b1;
               state_in = S_DONE;
            end else cmd.ins_scan = 1'b1;
         end
         S_DONE: begin
            if (!out_ff || rsp_ready) begin
               cmd.out_load = 1'b1;
               out_in = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         out_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         out_ff <= out_in;
      end
   end
endmodule

// ===== hdl/best_fit_free_list_allocator.sv =====
`timescale 1ns / 1ps
// Best-fit allocator over a sorted free list of up to 16 chunks.
// Requests arrive on req (command, request_size, block_base, block_length);
// one response per request leaves on rsp (status, data_offset,
// granted_base, granted_length). A request is accepted when valid and
// ready are both high at a rising clock edge.
// Processing time grows with N, the chunk count scanned, S the shift steps
// of one or two removals and P the insert position walk; it is set by the
// single list register file that is read one entry per cycle.
// One request is processed at a time; the next is taken once the response
// register is free.
// Reset (synchronous, active high) empties the list; software frees the
// whole pool once to seed it. A stalled receiver holds the response in
// its register and the block takes no new request until it is drained.
module best_fit_free_list_allocator (
   input logic clock,
   input logic reset,
   bffla_req_if.sink req_if,
   bffla_rsp_if.source rsp_if
);
   bffla_pkg::cmd_type cmd;
   bffla_pkg::sts_type sts;

   bffla_ctrl u_ctrl (
      .clock(clock), .reset(reset),
      .req_valid(req_if.valid), .req_ready(req_if.ready),
      .rsp_valid(rsp_if.valid), .rsp_ready(rsp_if.ready),
      .sts(sts), .cmd(cmd)
   );

   bffla_datapath u_dp (
      .clock(clock), .reset(reset),
      .req_in(req_if.payload), .cmd(cmd), .sts(sts),
      .rsp_data(rsp_if.payload)
   );

   // hold the response steady while the receiver stalls
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_if.valid && !rsp_if.ready |=> rsp_if.valid && $stable(rsp_if.payload))
      else $error("response dropped while stalled");
   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      req_if.valid && req_if.ready |=> !req_if.ready)
      else $error("request taken while busy");
   a_cmd_excl: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.alloc_take, cmd.free_merge, cmd.ins_write, cmd.load}))
      else $error("conflicting datapath commands");
endmodule
